// File: rtl/dga_pkg.sv
// Shared types, constants and calendar tables for the date adjust block.
package dga_pkg;

	// Field widths of the request and response items.
	localparam int OPC_W   = 3;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 10;
	localparam int WDAY_W  = 3;

	// Internal widths.
	localparam int YACC_W  = 22;  // signed year, holds the year minus 1023 millennia
	localparam int CNT_W   = 13;  // day steps left, up to 1023 weeks
	localparam int MUL_A_W = 15;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int YPROD_W = 20;  // count times the year unit fits here
	localparam int SUM_W   = 15;  // weekday sum before the reduction by seven
	localparam int Q100_W  = 8;
	localparam int Q7_W    = 12;
	localparam int PC_W    = 5;

	// Reciprocals for division by 100 and by 7, both scaled by 2**RECIP_SHIFT.
	localparam int RECIP_SHIFT = 19;
	localparam logic [MUL_B_W-1:0] RECIP_100 = 17'd5243;
	localparam logic [MUL_B_W-1:0] RECIP_7   = 17'd74899;

	localparam logic signed [YACC_W-1:0] YEAR_MAX = 22'sd16383;

	// Opcodes.
	localparam logic [OPC_W-1:0] OPC_ADD_DAY   = 3'd0;
	localparam logic [OPC_W-1:0] OPC_DAYS      = 3'd1;
	localparam logic [OPC_W-1:0] OPC_WEEKS     = 3'd2;
	localparam logic [OPC_W-1:0] OPC_MONTHS    = 3'd3;
	localparam logic [OPC_W-1:0] OPC_YEARS     = 3'd4;
	localparam logic [OPC_W-1:0] OPC_DECADES   = 3'd5;
	localparam logic [OPC_W-1:0] OPC_CENTURIES = 3'd6;
	localparam logic [OPC_W-1:0] OPC_MILLENNIA = 3'd7;

	// Month numbers that the datapath tests.
	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	// Microprogram entry points.
	localparam logic [PC_W-1:0] PC_START = 5'd0;
	localparam logic [PC_W-1:0] PC_ADD   = 5'd4;
	localparam logic [PC_W-1:0] PC_DAY   = 5'd5;
	localparam logic [PC_W-1:0] PC_MON   = 5'd9;
	localparam logic [PC_W-1:0] PC_YRS   = 5'd13;
	localparam logic [PC_W-1:0] PC_WK    = 5'd19;
	localparam logic [PC_W-1:0] PC_FIN   = 5'd25;

	typedef struct packed {
		logic [OPC_W-1:0]   opcode;
		logic [YEAR_W-1:0]  year_in;
		logic [MONTH_W-1:0] month_in;
		logic [DAY_W-1:0]   day_in;
		logic [COUNT_W-1:0] step_count;
	} req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year_out;
		logic [MONTH_W-1:0] month_out;
		logic [DAY_W-1:0]   day_out;
		logic [WDAY_W-1:0]  weekday;
		logic               error_flag;
	} rsp_t;

	// Datapath operations, one per microinstruction.
	typedef enum logic [3:0] {
		DP_NOP,
		DP_MUL_Y,
		DP_LEAP,
		DP_NORM,
		DP_ADD_DAY,
		DP_SUB_DAY,
		DP_SUB_MONTH,
		DP_MUL_N,
		DP_SUB_PROD,
		DP_WK_YY,
		DP_MUL_YY,
		DP_WK_SUM,
		DP_MUL_SUM,
		DP_WK_MOD,
		DP_FINISH
	} dp_op_t;

	// Branch conditions.
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_ERR,
		C_DONE,
		C_DAY_CONT,
		C_MON_CONT,
		C_OUT_BUSY
	} cond_t;

	// Sequencing modes of a microinstruction.
	typedef enum logic [1:0] {
		SQ_NEXT,
		SQ_BRANCH,
		SQ_DISPATCH,
		SQ_END
	} seq_t;

	typedef struct packed {
		dp_op_t          op;
		seq_t            seq;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic   load;
		dp_op_t op;
	} dp_ctrl_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic             err;
		logic             done;
		logic             jan1;
		logic             jan;
		logic             out_busy;
	} dp_status_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	// Length of a month; February follows the leap flag.
	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// Month term of the weekday formula: (31 * shifted month) / 12.
	function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] ofs;
		unique case (m)
			4'd1:    ofs = 5'd28;
			4'd2:    ofs = 5'd31;
			4'd3:    ofs = 5'd2;
			4'd4:    ofs = 5'd5;
			4'd5:    ofs = 5'd7;
			4'd6:    ofs = 5'd10;
			4'd7:    ofs = 5'd12;
			4'd8:    ofs = 5'd15;
			4'd9:    ofs = 5'd18;
			4'd10:   ofs = 5'd20;
			4'd11:   ofs = 5'd23;
			default: ofs = 5'd25;
		endcase
		return ofs;
	endfunction

	// Number of years in one unit of a year-type opcode.
	function automatic logic [COUNT_W-1:0] year_unit(input logic [OPC_W-1:0] op);
		logic [COUNT_W-1:0] unit;
		unique case (op)
			OPC_YEARS:     unit = 10'd1;
			OPC_DECADES:   unit = 10'd10;
			OPC_CENTURIES: unit = 10'd100;
			default:       unit = 10'd1000;
		endcase
		return unit;
	endfunction

	// Entry point of the routine that serves an opcode.
	function automatic logic [PC_W-1:0] dispatch(input logic [OPC_W-1:0] op);
		logic [PC_W-1:0] pc;
		unique case (op)
			OPC_ADD_DAY:          pc = PC_ADD;
			OPC_DAYS, OPC_WEEKS:  pc = PC_DAY;
			OPC_MONTHS:           pc = PC_MON;
			default:              pc = PC_YRS;
		endcase
		return pc;
	endfunction

endpackage

// File: rtl/dga_ucode_rom.sv
// Control store: the microprogram that runs one date adjustment.
module dga_ucode_rom
	import dga_pkg::*;
(
	input  logic [PC_W-1:0] pc,
	output uword_t          uword
);

	// One control word per step: datapath operation, sequencing, condition, target.
	always_comb begin
		unique case (pc)
			// Reject a bad input, then find the leap flag and normalize the day.
			PC_W'(0):  uword = '{DP_NOP,       SQ_BRANCH,   C_ERR,      PC_FIN};
			PC_W'(1):  uword = '{DP_MUL_Y,     SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(2):  uword = '{DP_LEAP,      SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(3):  uword = '{DP_NORM,      SQ_DISPATCH, C_ALWAYS,   PC_START};
			// Add one day.
			PC_W'(4):  uword = '{DP_ADD_DAY,   SQ_BRANCH,   C_ALWAYS,   PC_WK};
			// Day loop; a year crossing refreshes the leap flag.
			PC_W'(5):  uword = '{DP_SUB_DAY,   SQ_BRANCH,   C_DAY_CONT, PC_DAY};
			PC_W'(6):  uword = '{DP_NOP,       SQ_BRANCH,   C_DONE,     PC_WK};
			PC_W'(7):  uword = '{DP_MUL_Y,     SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(8):  uword = '{DP_LEAP,      SQ_BRANCH,   C_ALWAYS,   PC_DAY};
			// Month loop, same shape as the day loop.
			PC_W'(9):  uword = '{DP_SUB_MONTH, SQ_BRANCH,   C_MON_CONT, PC_MON};
			PC_W'(10): uword = '{DP_NOP,       SQ_BRANCH,   C_DONE,     PC_WK};
			PC_W'(11): uword = '{DP_MUL_Y,     SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(12): uword = '{DP_LEAP,      SQ_BRANCH,   C_ALWAYS,   PC_MON};
			// Years, decades, centuries, millennia: subtract at once, then clamp.
			PC_W'(13): uword = '{DP_MUL_N,     SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(14): uword = '{DP_SUB_PROD,  SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(15): uword = '{DP_NOP,       SQ_BRANCH,   C_ERR,      PC_FIN};
			PC_W'(16): uword = '{DP_MUL_Y,     SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(17): uword = '{DP_LEAP,      SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(18): uword = '{DP_NORM,      SQ_NEXT,     C_ALWAYS,   PC_START};
			// Weekday of the result.
			PC_W'(19): uword = '{DP_NOP,       SQ_BRANCH,   C_ERR,      PC_FIN};
			PC_W'(20): uword = '{DP_WK_YY,     SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(21): uword = '{DP_MUL_YY,    SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(22): uword = '{DP_WK_SUM,    SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(23): uword = '{DP_MUL_SUM,   SQ_NEXT,     C_ALWAYS,   PC_START};
			PC_W'(24): uword = '{DP_WK_MOD,    SQ_NEXT,     C_ALWAYS,   PC_START};
			// Hand the item to the output register, waiting while it is full.
			PC_W'(25): uword = '{DP_FINISH,    SQ_END,      C_OUT_BUSY, PC_FIN};
			default:   uword = '{DP_NOP,       SQ_BRANCH,   C_ALWAYS,   PC_FIN};
		endcase
	end

endmodule

// File: rtl/dga_sequencer.sv
// Microprogram sequencer: step counter, branch logic and run state.
module dga_sequencer
	import dga_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output logic       busy,
	output dp_ctrl_t   ctrl
);

	seq_state_t      state_q, state_n;
	logic [PC_W-1:0] pc_q, pc_n;
	uword_t          uword;
	logic            cond_true;

	dga_ucode_rom u_rom (
		.pc    (pc_q),
		.uword (uword)
	);

	// Evaluate the branch condition of the current step.
	always_comb begin
		unique case (uword.cond)
			C_ALWAYS:   cond_true = 1'b1;
			C_ERR:      cond_true = status.err;
			C_DONE:     cond_true = status.done;
			C_DAY_CONT: cond_true = !status.done && !status.jan1;
			C_MON_CONT: cond_true = !status.done && !status.jan;
			C_OUT_BUSY: cond_true = status.out_busy;
			default:    cond_true = 1'b0;
		endcase
	end

	// Next state and next step.
	always_comb begin
		state_n = state_q;
		pc_n    = PC_START;
		unique case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_n = SEQ_RUN;
				end
			end
			SEQ_RUN: begin
				unique case (uword.seq)
					SQ_NEXT:     pc_n = pc_q + PC_W'(1);
					SQ_BRANCH:   pc_n = cond_true ? uword.target : pc_q + PC_W'(1);
					SQ_DISPATCH: pc_n = dispatch(status.opcode);
					SQ_END: begin
						if (cond_true) begin
							pc_n = uword.target;
						end else begin
							state_n = SEQ_IDLE;
						end
					end
					default:     pc_n = PC_START;
				endcase
			end
			default: state_n = SEQ_IDLE;
		endcase
	end

	// Outputs toward the datapath and the request channel.
	always_comb begin
		busy      = (state_q == SEQ_RUN);
		ctrl.load = start;
		ctrl.op   = (state_q == SEQ_RUN) ? uword.op : DP_NOP;
	end

	// Run state and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			pc_q    <= PC_START;
		end else begin
			state_q <= state_n;
			pc_q    <= pc_n;
		end
	end

endmodule

// File: rtl/dga_datapath.sv
// Date registers, shared multiplier, calendar logic and the output register.
module dga_datapath
	import dga_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  dp_ctrl_t   ctrl,
	output dp_status_t status,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp
);

	logic [OPC_W-1:0]          opcode_q;
	logic signed [YACC_W-1:0]  year_q;
	logic [MONTH_W-1:0]        month_q;
	logic [DAY_W-1:0]          day_q;
	logic [COUNT_W-1:0]        count_q;
	logic [CNT_W-1:0]          remain_q;
	logic                      err_q;
	logic                      leap_q;
	logic [PROD_W-1:0]         prod_q;
	logic [YEAR_W-1:0]         yy_q;
	logic [SUM_W-1:0]          sum_q;
	logic [WDAY_W-1:0]         wday_q;
	rsp_t                      rsp_q;
	logic                      rsp_valid_q;

	logic                      year_pos, year_bad, err_now, done, jan, jan1;
	logic                      out_busy, finish_fire;
	logic [YEAR_W-1:0]         year14, hund, r100, yy_n;
	logic [Q100_W-1:0]         q100;
	logic [Q7_W-1:0]           q7;
	logic                      leap_n;
	logic [DAY_W-1:0]          len_cur, len_prev;
	logic [MUL_A_W-1:0]        mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic [PROD_W-1:0]         prod_n;
	logic [SUM_W-1:0]          sum_n, wday_n;

	// Year range and loop status.
	assign year_pos = (year_q > 0);
	assign year_bad = !year_pos || (year_q > YEAR_MAX);
	assign err_now  = err_q || year_bad;
	assign done     = (remain_q == '0) || !year_pos;
	assign jan      = (month_q == MON_JAN);
	assign jan1     = jan && (day_q == DAY_W'(1));
	assign year14   = year_q[YEAR_W-1:0];

	// Leap test from the registered quotient by 100.
	assign q100   = prod_q[RECIP_SHIFT +: Q100_W];
	assign hund   = {q100, 6'd0} + {1'b0, q100, 5'd0} + {4'd0, q100, 2'd0};
	assign r100   = year14 - hund;
	assign leap_n = ((year14[1:0] == 2'd0) && (r100 != '0)) ||
	                ((r100 == '0) && (q100[1:0] == 2'd0));

	// Month lengths for the current and the preceding month.
	assign len_cur  = days_in(month_q, leap_q);
	assign len_prev = days_in(month_q - MONTH_W'(1), leap_q);

	// Shared multiplier operands.
	always_comb begin
		unique case (ctrl.op)
			DP_MUL_Y: begin
				mul_a = MUL_A_W'(year14);
				mul_b = RECIP_100;
			end
			DP_MUL_YY: begin
				mul_a = MUL_A_W'(yy_q);
				mul_b = RECIP_100;
			end
			DP_MUL_N: begin
				mul_a = MUL_A_W'(count_q);
				mul_b = MUL_B_W'(year_unit(opcode_q));
			end
			DP_MUL_SUM: begin
				mul_a = sum_q;
				mul_b = RECIP_7;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod_n = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Weekday terms: shifted year, the sum, and the sum reduced by seven.
	assign yy_n   = year14 - YEAR_W'(month_q <= MON_FEB);
	assign sum_n  = SUM_W'(day_q) + SUM_W'(yy_q) + SUM_W'(yy_q[YEAR_W-1:2])
	              - SUM_W'(q100) + SUM_W'(q100[Q100_W-1:2])
	              + SUM_W'(month_offset(month_q));
	assign q7     = prod_q[RECIP_SHIFT +: Q7_W];
	assign wday_n = sum_q - SUM_W'({q7, 3'd0}) + SUM_W'(q7);

	assign out_busy    = rsp_valid_q && !rsp_ready;
	assign finish_fire = (ctrl.op == DP_FINISH) && !out_busy;

	// Working registers, driven by the load strobe and the current operation.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			opcode_q <= req.opcode;
			year_q   <= YACC_W'(req.year_in);
			month_q  <= req.month_in;
			day_q    <= req.day_in;
			count_q  <= req.step_count;
			err_q    <= (req.month_in == '0) || (req.month_in > MON_DEC) ||
			            (req.year_in == '0);
			if (req.opcode == OPC_WEEKS) begin
				remain_q <= CNT_W'({req.step_count, 3'd0}) - CNT_W'(req.step_count);
			end else begin
				remain_q <= CNT_W'(req.step_count);
			end
		end else begin
			unique case (ctrl.op)
				DP_MUL_Y, DP_MUL_YY, DP_MUL_N, DP_MUL_SUM: begin
					prod_q <= prod_n;
				end
				DP_LEAP: begin
					leap_q <= leap_n;
				end
				DP_NORM: begin
					if (day_q == '0) begin
						day_q <= DAY_W'(1);
					end else if (day_q > len_cur) begin
						day_q <= len_cur;
					end
				end
				DP_ADD_DAY: begin
					if (day_q == len_cur) begin
						day_q <= DAY_W'(1);
						if (month_q == MON_DEC) begin
							month_q <= MON_JAN;
							year_q  <= year_q + 22'sd1;
						end else begin
							month_q <= month_q + MONTH_W'(1);
						end
					end else begin
						day_q <= day_q + DAY_W'(1);
					end
				end
				DP_SUB_DAY: begin
					if (!done) begin
						remain_q <= remain_q - CNT_W'(1);
						if (day_q == DAY_W'(1)) begin
							if (jan) begin
								year_q  <= year_q - 22'sd1;
								month_q <= MON_DEC;
								day_q   <= DAY_W'(31);
							end else begin
								month_q <= month_q - MONTH_W'(1);
								day_q   <= len_prev;
							end
						end else begin
							day_q <= day_q - DAY_W'(1);
						end
					end
				end
				DP_SUB_MONTH: begin
					if (!done) begin
						remain_q <= remain_q - CNT_W'(1);
						if (jan) begin
							year_q  <= year_q - 22'sd1;
							month_q <= MON_DEC;
						end else begin
							month_q <= month_q - MONTH_W'(1);
							if (day_q > len_prev) begin
								day_q <= len_prev;
							end
						end
					end
				end
				DP_SUB_PROD: begin
					year_q <= year_q - $signed(YACC_W'(prod_q[YPROD_W-1:0]));
				end
				DP_WK_YY: begin
					yy_q <= yy_n;
				end
				DP_WK_SUM: begin
					sum_q <= sum_n;
				end
				DP_WK_MOD: begin
					wday_q <= wday_n[WDAY_W-1:0];
				end
				DP_FINISH: begin
					if (finish_fire) begin
						if (err_now) begin
							rsp_q <= '{year_out: '0, month_out: '0, day_out: '0,
							           weekday: '0, error_flag: 1'b1};
						end else begin
							rsp_q <= '{year_out: year14, month_out: month_q,
							           day_out: day_q, weekday: wday_q, error_flag: 1'b0};
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output valid: set when a result is written, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign status = '{opcode: opcode_q, err: err_now, done: done, jan1: jan1,
	                  jan: jan, out_busy: out_busy};

endmodule

// File: rtl/gregorian_date_adjust_top.sv
// Each request runs one microprogram routine. Add one day and the year, decade, century
// and millennium steps run straight through; day and week steps loop once per day and
// refresh the leap flag at each year boundary crossed; month steps loop once per month
// likewise. An invalid input goes straight to the finish step. One item at a time: a
// new item is taken only while idle, and a stalled output holds the finish step.
// Reset: arst_n clears the sequencer and the output valid; no clearing pass.
module gregorian_date_adjust_top
	import dga_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_item,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_item
);

	logic       busy;
	logic       start;
	dp_ctrl_t   ctrl;
	dp_status_t status;

	// A new item is taken whenever the sequencer is idle.
	assign req_ready = !busy;
	assign start     = req_valid && req_ready;

	dga_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	dga_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_item),
		.ctrl      (ctrl),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp_item)
	);

endmodule

// File: rtl/dga_checker.sv
// Port-level checks of the date adjust block and their bind to the top level.
module dga_checker
	import dga_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_item
);

	// One item at a time: after an accept the request side closes.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while an item is in progress");

	// An error result carries all-zero date fields.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.error_flag |->
			rsp_item.year_out == '0 && rsp_item.month_out == '0 &&
			rsp_item.day_out == '0 && rsp_item.weekday == '0)
		else $error("error result with nonzero fields");

	// A good result is a real date with a real weekday.
	a_good_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.error_flag |->
			rsp_item.year_out != '0 && rsp_item.month_out >= 4'd1 &&
			rsp_item.month_out <= 4'd12 && rsp_item.day_out >= 5'd1 &&
			rsp_item.weekday <= 3'd6)
		else $error("result date or weekday out of range");

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
		else $error("stalled result changed or dropped");

endmodule

bind gregorian_date_adjust_top dga_checker u_dga_checker (.*);

// File: tb/gregorian_date_adjust_top_tb.sv
// Self-checking testbench for the Gregorian date adjust block with a scoreboard class.
`timescale 1ns / 1ps

module gregorian_date_adjust_top_tb;
	import dga_pkg::*;

	localparam int COUNT_CAP   = 1023;
	localparam int YEAR_TOP    = 16383;
	localparam int RANDOM_REQS = 650;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int DRAIN_WAIT  = 40;

	// Predicts one date result per request and checks the block's results in order.
	class date_scoreboard;
		rsp_t pending[$];
		int   errors;
		int   checked;
		int   flagged;
		int   op_seen[8];

		function bit leap_year(int y);
			return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
		endfunction

		function int month_length(int m, int y);
			int len;
			case (m)
				2:             len = leap_year(y) ? 29 : 28;
				4, 6, 9, 11:   len = 30;
				default:       len = 31;
			endcase
			return len;
		endfunction

		// Day of week, 0 for Sunday, with March taken as the first month.
		function int day_of_week(int y, int m, int d);
			int a;
			int yy;
			int mm;
			a  = (14 - m) / 12;
			yy = y - a;
			mm = m + 12 * a - 2;
			return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
		endfunction

		function rsp_t predict_date(req_t r);
			int   y;
			int   m;
			int   d;
			int   n;
			int   len;
			int   total;
			int   unit;
			bit   err;
			rsp_t p;
			y   = int'(r.year_in);
			m   = int'(r.month_in);
			d   = int'(r.day_in);
			n   = int'(r.step_count);
			err = 1'b0;
			if (n > COUNT_CAP)
				n = COUNT_CAP;
			if (m < 1 || m > 12 || y < 1) begin
				err = 1'b1;
			end else begin
				// Out-of-range days are pulled into the month first.
				len = month_length(m, y);
				if (d < 1)
					d = 1;
				if (d > len)
					d = len;
				case (r.opcode)
					OPC_ADD_DAY: begin
						if (d == len) begin
							d = 1;
							if (m == 12) begin
								m = 1;
								y++;
							end else begin
								m++;
							end
						end else begin
							d++;
						end
					end
					OPC_DAYS, OPC_WEEKS: begin
						total = (r.opcode == OPC_WEEKS) ? n * 7 : n;
						for (int i = 0; i < total && y >= 1; i++) begin
							if (d == 1) begin
								if (m == 1) begin
									y--;
									m = 12;
									d = 31;
								end else begin
									m--;
									d = month_length(m, y);
								end
							end else begin
								d--;
							end
						end
					end
					OPC_MONTHS: begin
						// The day is clamped after every single month, so clamps add up.
						for (int i = 0; i < n && y >= 1; i++) begin
							if (m == 1) begin
								y--;
								m = 12;
							end else begin
								m--;
							end
							if (y >= 1) begin
								len = month_length(m, y);
								if (d > len)
									d = len;
							end
						end
					end
					default: begin
						case (r.opcode)
							OPC_YEARS:     unit = 1;
							OPC_DECADES:   unit = 10;
							OPC_CENTURIES: unit = 100;
							default:       unit = 1000;
						endcase
						y -= n * unit;
						if (y >= 1) begin
							len = month_length(m, y);
							if (d > len)
								d = len;
						end
					end
				endcase
				if (y < 1 || y > YEAR_TOP)
					err = 1'b1;
			end
			p = '0;
			if (err) begin
				p.error_flag = 1'b1;
			end else begin
				p.year_out  = YEAR_W'(y);
				p.month_out = MONTH_W'(m);
				p.day_out   = DAY_W'(d);
				p.weekday   = WDAY_W'(day_of_week(y, m, d));
			end
			return p;
		endfunction

		function void note_request(req_t r);
			rsp_t p;
			p = predict_date(r);
			op_seen[r.opcode]++;
			if (p.error_flag)
				flagged++;
			pending.push_back(p);
		endfunction

		function void compare_field(string field, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			compare_field("year_out", int'(want.year_out), int'(got.year_out));
			compare_field("month_out", int'(want.month_out), int'(got.month_out));
			compare_field("day_out", int'(want.day_out), int'(got.day_out));
			compare_field("weekday", int'(want.weekday), int'(got.weekday));
			compare_field("error_flag", int'(want.error_flag), int'(got.error_flag));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_item;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_item;

	date_scoreboard sb;
	bit quiet;
	int stall_left;
	int cycles;

	gregorian_date_adjust_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly no gap, some short ones, a few long ones; none in quiet stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic req_t make_req(logic [OPC_W-1:0] op, int y, int m, int d, int n);
		req_t r;
		r.opcode     = op;
		r.year_in    = YEAR_W'(y);
		r.month_in   = MONTH_W'(m);
		r.day_in     = DAY_W'(d);
		r.step_count = COUNT_W'(n);
		return r;
	endfunction

	// Random request; counts stay mostly small so that slow day loops remain rare.
	function automatic req_t random_req();
		req_t r;
		int   sel;
		int   unit;
		r.opcode = OPC_W'($urandom_range(0, 7));
		sel = $urandom_range(0, 99);
		if (sel < 80)
			r.year_in = YEAR_W'($urandom_range(1, 9999));
		else if (sel < 92)
			r.year_in = YEAR_W'($urandom_range(0, YEAR_TOP));
		else if (sel < 96)
			r.year_in = YEAR_W'($urandom_range(1, 3));
		else
			r.year_in = '0;
		if ($urandom_range(0, 9) == 0)
			r.month_in = MONTH_W'($urandom_range(0, 15));
		else
			r.month_in = MONTH_W'($urandom_range(1, 12));
		r.day_in   = DAY_W'($urandom_range(0, 31));
		sel = $urandom_range(0, 99);
		case (r.opcode)
			OPC_DAYS, OPC_WEEKS:
				r.step_count = COUNT_W'((sel < 85) ? $urandom_range(0, 40) :
					$urandom_range(0, COUNT_CAP));
			OPC_MONTHS:
				r.step_count = COUNT_W'((sel < 88) ? $urandom_range(0, 60) :
					$urandom_range(0, COUNT_CAP));
			OPC_YEARS, OPC_DECADES, OPC_CENTURIES, OPC_MILLENNIA: begin
				unit = (r.opcode == OPC_YEARS) ? 1 : (r.opcode == OPC_DECADES) ? 10 :
					(r.opcode == OPC_CENTURIES) ? 100 : 1000;
				if (sel < 80) begin
					r.step_count = COUNT_W'($urandom_range(0, int'(r.year_in) / unit + 1));
					if (int'(r.year_in) / unit + 1 > COUNT_CAP)
						r.step_count = COUNT_W'($urandom_range(0, COUNT_CAP));
				end else begin
					r.step_count = COUNT_W'($urandom_range(0, COUNT_CAP));
				end
			end
			default:
				r.step_count = COUNT_W'($urandom_range(0, COUNT_CAP));
		endcase
		return r;
	endfunction

	// Presents one request and returns at the edge where it is taken.
	task automatic send_req(input req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_item  <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// Result side: random stalls on ready.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ready  <= 1'b1;
			stall_left <= pick_stall();
		end
	end

	// Watch both channels and feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req_item);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp_item);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycles, sb.pending.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		sb        = new();
		quiet     = 1'b0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_item  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: calendar edges, clamps, error cases and count extremes.
		send_req(make_req(OPC_ADD_DAY, YEAR_TOP, 12, 31, 0));
		send_req(make_req(OPC_ADD_DAY, 1999, 12, 31, COUNT_CAP));
		send_req(make_req(OPC_ADD_DAY, 2000, 2, 28, 0));
		send_req(make_req(OPC_ADD_DAY, 1900, 2, 28, 0));
		send_req(make_req(OPC_ADD_DAY, 2001, 2, 31, 5));
		send_req(make_req(OPC_DAYS, 2020, 0, 10, 3));
		send_req(make_req(OPC_MONTHS, 2020, 13, 10, 3));
		send_req(make_req(OPC_YEARS, 2020, 15, 10, 3));
		send_req(make_req(OPC_DAYS, 0, 6, 15, 1));
		send_req(make_req(OPC_DAYS, 2021, 3, 0, 0));
		send_req(make_req(OPC_YEARS, 2021, 4, 31, 0));
		send_req(make_req(OPC_DAYS, 1, 1, 1, 1));
		send_req(make_req(OPC_DAYS, 1, 1, 1, 0));
		send_req(make_req(OPC_DAYS, 2000, 3, 1, 1));
		send_req(make_req(OPC_WEEKS, 9999, 12, 31, COUNT_CAP));
		send_req(make_req(OPC_DAYS, YEAR_TOP, 12, 31, COUNT_CAP));
		send_req(make_req(OPC_MONTHS, 2001, 3, 31, 2));
		send_req(make_req(OPC_MONTHS, 100, 5, 31, COUNT_CAP));
		send_req(make_req(OPC_YEARS, 2000, 2, 29, 1));
		send_req(make_req(OPC_YEARS, 1024, 7, 4, COUNT_CAP));
		send_req(make_req(OPC_DECADES, 2000, 2, 29, 1));
		send_req(make_req(OPC_CENTURIES, 2000, 2, 29, 1));
		send_req(make_req(OPC_CENTURIES, YEAR_TOP, 8, 20, COUNT_CAP));
		send_req(make_req(OPC_MILLENNIA, 2000, 2, 29, 1));
		send_req(make_req(OPC_MILLENNIA, 9999, 9, 9, COUNT_CAP));

		// Random part, with quiet stretches that drop all idling on both sides.
		for (int k = 0; k < RANDOM_REQS; k++) begin
			if (k % 60 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			send_req(random_req());
		end
		req_valid <= 1'b0;
		quiet = 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d results over all eight opcodes, %0d of them error results.",
			sb.checked, sb.flagged);
		$display("Requests per opcode: %0d %0d %0d %0d %0d %0d %0d %0d", sb.op_seen[0],
			sb.op_seen[1], sb.op_seen[2], sb.op_seen[3], sb.op_seen[4], sb.op_seen[5],
			sb.op_seen[6], sb.op_seen[7]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/dga_pkg.sv
rtl/dga_ucode_rom.sv
rtl/dga_sequencer.sv
rtl/dga_datapath.sv
rtl/gregorian_date_adjust_top.sv
rtl/dga_checker.sv
tb/gregorian_date_adjust_top_tb.sv
